FILE: hw/rtl/vpcg_pkg.sv
package vpcg_pkg;

	localparam int PIPE_DEPTH = 27;
	localparam int DIV_STEPS  = 17;
	localparam int DEG_STEPS  = 9;
	localparam int SKID_DEPTH = 2;

	typedef enum logic [1:0] {
		CFG_REGION_SWAP     = 2'd0,
		CFG_LIGHTNESS_GAIN  = 2'd1,
		CFG_SATURATION_GAIN = 2'd2
	} cfg_idx_t;

	localparam logic [9:0]  GAIN_MAX    = 10'd1000;
	localparam logic [28:0] LUM_RECIP   = 29'd269488145;
	localparam logic [26:0] GAIN_RECIP  = 27'd68719477;
	localparam logic [26:0] DIV60_RECIP = 27'd71582789;

	localparam logic [2:0] TAB_BLUE  [16] = '{3'd7, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1, 3'd1, 3'd1};
	localparam logic [2:0] TAB_RED   [16] = '{3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1};
	localparam logic [2:0] TAB_GREEN [16] = '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd5, 3'd6, 3'd7, 3'd6, 3'd5, 3'd1, 3'd1, 3'd1};

	typedef struct packed {
		logic [8:0]  sat_den;
		logic [8:0]  sat_rem;
		logic [16:0] sat_q;
		logic [8:0]  deg_num;
		logic [7:0]  deg_den;
		logic [7:0]  deg_rem;
		logic [8:0]  deg_q;
		logic [8:0]  sum;
		logic [16:0] lum;
	} div_t;

	// one quotient bit of saturation per step and of hue per step below DEG_STEPS; lightness scaled on the first step
	function automatic div_t div_step(div_t x, int unsigned j);
		div_t        y;
		logic [9:0]  st;
		logic [8:0]  dt;
		logic [37:0] lp;
		y = x;
		if (j == 0) begin
			st = {1'b0, x.sat_rem};
		end else begin
			st = {x.sat_rem, 1'b0};
		end
		if (st >= {1'b0, x.sat_den}) begin
			y.sat_rem = 9'(st - {1'b0, x.sat_den});
			y.sat_q   = {x.sat_q[15:0], 1'b1};
		end else begin
			y.sat_rem = st[8:0];
			y.sat_q   = {x.sat_q[15:0], 1'b0};
		end
		if (j < DEG_STEPS) begin
			dt        = {x.deg_rem, x.deg_num[8]};
			y.deg_num = {x.deg_num[7:0], 1'b0};
			if (dt >= {1'b0, x.deg_den}) begin
				y.deg_rem = 8'(dt - {1'b0, x.deg_den});
				y.deg_q   = {x.deg_q[7:0], 1'b1};
			end else begin
				y.deg_rem = dt[7:0];
				y.deg_q   = {x.deg_q[7:0], 1'b0};
			end
		end
		if (j == 0) begin
			lp    = 38'(x.sum) * 38'(LUM_RECIP);
			y.lum = lp[37:21];
		end
		return y;
	endfunction

endpackage

FILE: hw/rtl/video_palette_color_generator_core.sv
// Palette to RGB generator with lightness and saturation lift. One transaction enters per
// clock while in_ready is high; a result passes through a 27-stage pipeline (17 of its
// stages are the shared bit-serial divider for saturation and hue) followed by a two-entry
// output skid buffer. A stalled output keeps taking input until the skid buffer is full.
// Configuration writes complete at once and must be made only while no transaction is in
// flight.
module video_palette_color_generator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [9:0] palette_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	localparam int N = vpcg_pkg::PIPE_DEPTH;
	localparam int D = vpcg_pkg::DIV_STEPS;

	logic       swap_q;
	logic [9:0] lgain_q;
	logic [9:0] sgain_q;

	logic [N-1:0] vld_q;
	logic         en;

	logic [7:0] r_s1, g_s1, b_s1;
	vpcg_pkg::div_t st_s2;
	vpcg_pkg::div_t div_s3 [D];

	logic [26:0] al_s20, as_s20;
	logic [16:0] lum_s20, sat_s20;
	logic [5:0]  w_s20 [3];
	logic [53:0] lp_s21, sp_s21;
	logic [16:0] lum_s21, sat_s21;
	logic [5:0]  w_s21 [3];
	logic [16:0] lum_s22, sat_s22;
	logic [5:0]  w_s22 [3];
	logic [33:0] ls_s23;
	logic [16:0] lum_s23, sat_s23;
	logic [5:0]  w_s23 [3];
	logic [16:0] p1_s24, dif_s24;
	logic [5:0]  w_s24 [3];
	logic [22:0] y_s25 [3];
	logic [16:0] p1_s25;
	logic [49:0] z_s26 [3];
	logic [16:0] p1_s26;
	logic [7:0]  c_s27 [3];

	logic       skid_v_q;
	logic [7:0] skid_q [3];
	logic [7:0] head_q [3];

	// decode
	logic [3:0] step;
	logic [1:0] lvl;
	logic       er, eg, eb;
	logic [7:0] r_d, g_d, b_d;

	always_comb begin
		step = palette_index[6] ? 4'd0 : palette_index[3:0];
		lvl  = (step >= 4'd14) ? 2'd0 : palette_index[5:4];
		er   = swap_q ? palette_index[8] : palette_index[7];
		eg   = swap_q ? palette_index[7] : palette_index[8];
		eb   = palette_index[9];
		r_d  = {lvl, vpcg_pkg::TAB_RED[step],   {3{er}}};
		g_d  = {lvl, vpcg_pkg::TAB_GREEN[step], {3{eg}}};
		b_d  = {lvl, vpcg_pkg::TAB_BLUE[step],  {3{eb}}};
	end

	// min, max and divider operands
	logic [7:0]         mx, mn, dl;
	logic [8:0]         sm;
	logic signed [18:0] rs, gs, bs, ds, num;
	vpcg_pkg::div_t     st_d;

	always_comb begin
		mx  = (r_s1 > g_s1) ? r_s1 : g_s1;
		if (b_s1 > mx) mx = b_s1;
		mn  = (r_s1 < g_s1) ? r_s1 : g_s1;
		if (b_s1 < mn) mn = b_s1;
		dl  = 8'(mx - mn);
		sm  = 9'({1'b0, mx} + {1'b0, mn});
		rs  = $signed({11'b0, r_s1});
		gs  = $signed({11'b0, g_s1});
		bs  = $signed({11'b0, b_s1});
		ds  = $signed({11'b0, dl});
		if (r_s1 == mx) begin
			num = 19'(19'sd60 * (gs - bs));
		end else if (g_s1 == mx) begin
			num = 19'(19'sd120 * ds + 19'sd60 * (bs - rs));
		end else begin
			num = 19'(19'sd240 * ds + 19'sd60 * (rs - gs));
		end
		if (num < 0) num = 19'(num + 19'sd360 * ds);
		st_d       = '0;
		st_d.sum   = sm;
		if (dl == 8'd0) begin
			st_d.sat_den = 9'd1;
			st_d.deg_den = 8'd1;
		end else begin
			st_d.sat_den = (sm <= 9'd255) ? sm : 9'(10'd510 - {1'b0, sm});
			st_d.sat_rem = {1'b0, dl};
			st_d.deg_den = dl;
			st_d.deg_rem = num[16:9];
			st_d.deg_num = num[8:0];
		end
	end

	// hue weights
	function automatic logic [5:0] hue_weight(logic signed [10:0] x);
		logic signed [10:0] xr;
		logic [5:0]         w;
		if (x > 11'sd360) begin
			xr = 11'(x - 11'sd360);
		end else if (x < 11'sd0) begin
			xr = 11'(x + 11'sd360);
		end else begin
			xr = x;
		end
		if (xr < 11'sd60) begin
			w = xr[5:0];
		end else if (xr < 11'sd180) begin
			w = 6'd60;
		end else if (xr < 11'sd240) begin
			w = 6'(11'sd240 - xr);
		end else begin
			w = 6'd0;
		end
		return w;
	endfunction

	logic signed [10:0] hue;
	logic [16:0]        e_d, ll_d;

	always_comb begin
		hue  = 11'($signed({2'b0, div_s3[D-1].deg_q}) - 11'sd15);
		ll_d = ls_s23[32:16];
		if (lum_s23 <= 17'd32768) begin
			e_d = ll_d;
		end else begin
			e_d = 17'(sat_s23 - ll_d);
		end
	end

	logic [16:0] v_d [3];
	logic [24:0] t_d [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			v_d[c] = 17'(p1_s26 + z_s26[c][48:32]);
			t_d[c] = 25'({v_d[c], 8'b0}) - 25'(v_d[c]);
		end
	end

	assign en        = !skid_v_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q  <= 1'b0;
			lgain_q <= '0;
			sgain_q <= '0;
		end else if (cfg_valid) begin
			case (vpcg_pkg::cfg_idx_t'(cfg_index))
				vpcg_pkg::CFG_REGION_SWAP: swap_q <= cfg_data[0];
				vpcg_pkg::CFG_LIGHTNESS_GAIN:
					lgain_q <= (cfg_data > vpcg_pkg::GAIN_MAX) ? vpcg_pkg::GAIN_MAX : cfg_data;
				vpcg_pkg::CFG_SATURATION_GAIN:
					sgain_q <= (cfg_data > vpcg_pkg::GAIN_MAX) ? vpcg_pkg::GAIN_MAX : cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_d;
			g_s1 <= g_d;
			b_s1 <= b_d;
			st_s2 <= st_d;
			div_s3[0] <= vpcg_pkg::div_step(st_s2, 0);
			for (int j = 1; j < D; j++) begin
				div_s3[j] <= vpcg_pkg::div_step(div_s3[j-1], j);
			end
			lum_s20 <= div_s3[D-1].lum;
			sat_s20 <= div_s3[D-1].sat_q;
			al_s20  <= 17'(18'd65536 - {1'b0, div_s3[D-1].lum}) * 27'(lgain_q);
			as_s20  <= 17'(18'd65536 - {1'b0, div_s3[D-1].sat_q}) * 27'(sgain_q);
			w_s20[0] <= hue_weight(11'(hue + 11'sd120));
			w_s20[1] <= hue_weight(hue);
			w_s20[2] <= hue_weight(11'(hue - 11'sd120));
			lp_s21  <= 54'(al_s20) * 54'(vpcg_pkg::GAIN_RECIP);
			sp_s21  <= 54'(as_s20) * 54'(vpcg_pkg::GAIN_RECIP);
			lum_s21 <= lum_s20;
			sat_s21 <= sat_s20;
			w_s21   <= w_s20;
			lum_s22 <= 17'(lum_s21 + lp_s21[52:36]);
			sat_s22 <= 17'(sat_s21 + sp_s21[52:36]);
			w_s22   <= w_s21;
			ls_s23  <= 34'(lum_s22) * 34'(sat_s22);
			lum_s23 <= lum_s22;
			sat_s23 <= sat_s22;
			w_s23   <= w_s22;
			p1_s24  <= 17'(lum_s23 - e_d);
			dif_s24 <= 17'({e_d, 1'b0});
			w_s24   <= w_s23;
			for (int c = 0; c < 3; c++) begin
				y_s25[c] <= 23'(dif_s24) * 23'(w_s24[c]);
				z_s26[c] <= 50'(y_s25[c]) * 50'(vpcg_pkg::DIV60_RECIP);
				c_s27[c] <= t_d[c][23:16];
			end
			p1_s25 <= p1_s24;
			p1_s26 <= p1_s25;
		end
	end

	// output skid: head drives the ports, second entry holds on stall
	logic push, pop;

	assign push = en && vld_q[N-1];
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				out_valid <= push;
			end
		end else if (push) begin
			if (!out_valid) begin
				out_valid <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				skid_q <= c_s27;
			end else begin
				head_q <= c_s27;
			end
		end else if (push) begin
			if (!out_valid) begin
				head_q <= c_s27;
			end else begin
				skid_q <= c_s27;
			end
		end
	end

	assign red   = head_q[0];
	assign green = head_q[1];
	assign blue  = head_q[2];

endmodule

FILE: hw/rtl/vpcg_checker.sv
module vpcg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	localparam int MAX_FLIGHT = vpcg_pkg::PIPE_DEPTH + vpcg_pkg::SKID_DEPTH;

	logic [5:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 6'(cnt_q + 6'(in_valid && in_ready) - 6'(out_valid && out_ready));
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("output transaction changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with empty output");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 6'd0)
		else $error("result without an input transaction");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(MAX_FLIGHT))
		else $error("more transactions in flight than storage");

endmodule

bind video_palette_color_generator_core vpcg_checker u_vpcg_checker (.*);
